>>> rtl/kacc_pkg.sv
// Shared types and constants for the keyed-alphabet Caesar cipher.
// No dependencies; imported by the top level and the port checker.
package kacc_pkg;

    // Field widths fixed by the item format.
    localparam int SYM_W = 21;
    localparam int IDX_W = 5;
    localparam int KEY_W = 5;

    // Request codes carried on req_type.
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_KEYWORD = 2'd1;
    localparam logic [1:0] REQ_ENCRYPT = 2'd2;
    localparam logic [1:0] REQ_DECRYPT = 2'd3;

endpackage

>>> rtl/kacc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kacc_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 31
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds while not enabled.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/keyed_alphabet_caesar_cipher.sv
// Top level of the keyed-alphabet Caesar cipher: sequencer around the table RAM.
// Depends on kacc_pkg and kacc_ram.
//
//   Channel | Direction | Ports                                        | Flow control
//   s_      | in        | s_req_type, s_entry_index, s_symbol          | s_valid / s_ready
//   m_      | out       | m_out_symbol, m_found                        | m_valid / m_ready
//   cfg_    | in        | cfg_wr_data (shift key)                      | cfg_wr_en, no wait
//
// A load beat is written straight from the idle state; lookup beats, and keyword beats below a
// full prefix, scan the table through the single table RAM read port, which walks one entry per
// cycle. Reset is synchronous and needs no clearing pass; table entries are undefined until
// loaded. The result register lets a new beat be taken while a result waits; a lookup that
// finishes while the result register is still full waits for m_ready.
module keyed_alphabet_caesar_cipher
    import kacc_pkg::*;
#(
    parameter int ALPHABET_SIZE = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [KEY_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  logic [IDX_W-1:0] s_entry_index,
    input  logic [SYM_W-1:0] s_symbol,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [SYM_W-1:0] m_out_symbol,
    output logic             m_found
);

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int PW = $clog2(ALPHABET_SIZE + 1);
    localparam int SW = PW + 1;
    localparam int DW = PW + KEY_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       req_reg, req_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic [SYM_W-1:0] carry_reg, carry_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [PW-1:0]    count_reg, count_next;
    logic [AW-1:0]    key_reg;
    logic             found_reg, found_next;
    logic             m_valid_reg, m_valid_next;
    logic [SYM_W-1:0] m_out_symbol_reg, m_out_symbol_next;
    logic             m_found_reg, m_found_next;

    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [SYM_W-1:0] ram_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [SYM_W-1:0] ram_rd_data;

    logic [DW-1:0]    key_rem;
    logic [AW-1:0]    key_reduced;
    logic [SW-1:0]    shift_sum;
    logic [AW-1:0]    target_pos;
    logic             hit;
    logic             last;
    logic             below_count;
    logic             accept;
    logic             slot_free;

    kacc_ram #(
        .WIDTH (SYM_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_table (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Reduce the written key modulo the alphabet size by restoring subtraction.
    always_comb begin
        key_rem = DW'(cfg_wr_data);
        for (int i = KEY_W - 1; i >= 0; i--) begin
            if (key_rem >= (DW'(ALPHABET_SIZE) << i)) begin
                key_rem = key_rem - (DW'(ALPHABET_SIZE) << i);
            end
        end
        key_reduced = AW'(key_rem);
    end

    // Position of the result entry: the match position moved by the key, wrapped once.
    always_comb begin
        if (req_reg == REQ_ENCRYPT) begin
            shift_sum = SW'(pos_reg) + SW'(key_reg);
        end else begin
            shift_sum = SW'(pos_reg) + SW'(ALPHABET_SIZE) - SW'(key_reg);
        end
        if (shift_sum >= SW'(ALPHABET_SIZE)) begin
            target_pos = AW'(shift_sum - SW'(ALPHABET_SIZE));
        end else begin
            target_pos = AW'(shift_sum);
        end
    end

    assign hit         = (ram_rd_data == sym_reg);
    assign last        = (pos_reg == AW'(ALPHABET_SIZE - 1));
    assign below_count = (PW'(pos_reg) < count_reg);
    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign slot_free   = !m_valid_reg || m_ready;

    // Sequencer: one table entry is read per cycle; keyword beats rotate entries as they pass.
    always_comb begin
        state_next        = state_reg;
        req_next          = req_reg;
        sym_next          = sym_reg;
        carry_next        = carry_reg;
        pos_next          = pos_reg;
        count_next        = count_reg;
        found_next        = found_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_out_symbol_next = m_out_symbol_reg;
        m_found_next      = m_found_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = pos_reg;
        ram_wr_data       = carry_reg;
        ram_rd_en         = 1'b0;
        ram_rd_addr       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next   = s_req_type;
                    sym_next   = s_symbol;
                    carry_next = s_symbol;
                    pos_next   = '0;
                    case (s_req_type)
                        REQ_LOAD: begin
                            ram_wr_en   = (int'(s_entry_index) < ALPHABET_SIZE);
                            ram_wr_addr = AW'(s_entry_index);
                            ram_wr_data = s_symbol;
                            count_next  = '0;
                        end
                        REQ_KEYWORD: begin
                            // A full keyword prefix ignores further letters.
                            if (count_reg < PW'(ALPHABET_SIZE)) begin
                                ram_rd_en  = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            ram_rd_en  = 1'b1;
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (req_reg == REQ_KEYWORD) begin
                    if (below_count) begin
                        // Inside the keyword prefix: a match means a repeated letter.
                        if (hit) begin
                            state_next = ST_IDLE;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = pos_reg + AW'(1);
                            pos_next    = pos_reg + AW'(1);
                        end
                    end else begin
                        // Shift the carried entry in and pick up the old one.
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = pos_reg;
                        ram_wr_data = carry_reg;
                        carry_next  = ram_rd_data;
                        if (hit || last) begin
                            count_next = count_reg + PW'(1);
                            state_next = ST_IDLE;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = pos_reg + AW'(1);
                            pos_next    = pos_reg + AW'(1);
                        end
                    end
                end else begin
                    if (hit) begin
                        // Fetch the shifted entry for the result.
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = target_pos;
                        found_next  = 1'b1;
                        state_next  = ST_DONE;
                    end else if (last) begin
                        found_next = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pos_reg + AW'(1);
                        pos_next    = pos_reg + AW'(1);
                    end
                end
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (slot_free) begin
                    m_valid_next      = 1'b1;
                    m_out_symbol_next = found_reg ? ram_rd_data : sym_reg;
                    m_found_next      = found_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            key_reg     <= AW'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                key_reg <= key_reduced;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_reg          <= req_next;
        sym_reg          <= sym_next;
        carry_reg        <= carry_next;
        pos_reg          <= pos_next;
        found_reg        <= found_next;
        m_out_symbol_reg <= m_out_symbol_next;
        m_found_reg      <= m_found_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_symbol = m_out_symbol_reg;
    assign m_found      = m_found_reg;

endmodule

>>> rtl/kacc_checker.sv
// Port-level checker for the keyed-alphabet Caesar cipher, bound to the top level.
// Depends on kacc_pkg.
module kacc_checker
    import kacc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [1:0]       s_req_type,
    input logic             m_valid,
    input logic             m_ready,
    input logic [SYM_W-1:0] m_out_symbol,
    input logic             m_found
);

    // A stalled result beat holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_symbol) && $stable(m_found))
        else $error("result beat changed while stalled");

    // Reset leaves the block empty and ready.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    // The input side is ready again in the cycle after a load beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == REQ_LOAD) |=> s_ready)
        else $error("load beat did not complete in one cycle");

    // A lookup beat always scans the table, so the input side closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == REQ_ENCRYPT || s_req_type == REQ_DECRYPT)
        |=> !s_ready)
        else $error("lookup beat did not start a scan");

    // A new result only appears at the end of a lookup, while the input side was busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a lookup");

endmodule

bind keyed_alphabet_caesar_cipher kacc_checker u_kacc_checker (.*);
